// ===== rtl/ase_pkg.sv =====
package ase_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VALUE_W   = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic   insert;  // place the broadcast value in order
    logic   shift;   // move every entry one cell toward the head
    value_t value;
  } cell_ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    value_t value;
    logic   valid;
    logic   gt;      // empty, or holds a value above the broadcast value
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_LOAD   = 2'b01,
    ST_UNLOAD = 2'b10
  } ase_state_t;

endpackage

// ===== rtl/ase_cell.sv =====
module ase_cell
  import ase_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  cell_link_t from_left,
  input  cell_link_t from_right,
  output cell_link_t to_nbr
);

  value_t value_r, value_nxt;
  logic   valid_r, valid_nxt;
  logic   gt;

  assign gt = !valid_r || (value_r > ctrl.value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      value_nxt = from_right.value;
      valid_nxt = from_right.valid;
    end else if (ctrl.insert && gt) begin
      // left neighbor also larger: take its entry, else this is the slot
      if (from_left.gt) begin
        value_nxt = from_left.value;
        valid_nxt = from_left.valid;
      end else begin
        value_nxt = ctrl.value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign to_nbr = '{value: value_r, valid: valid_r, gt: gt};

endmodule

// ===== rtl/ascending_sort_engine.sv =====
// Ascending sort engine.
// Input channel (in_*): one signed 32-bit value per beat; in_final_item
// closes the set and that beat's value belongs to it. A value is taken
// each cycle while loading. At most MAX_ITEMS values are kept; further
// values of the same set are dropped and flagged.
// Output channel (out_*): after the final beat the stored values come out
// lowest first, one beat per cycle while out_stall is low, out_end_of_run
// on the last one and out_dropped on every beat of a set that lost values.
// Timing: the first sorted beat is offered in the cycle after the final
// input beat; a set unloads one beat per kept value, holding while stalled.
// Throughput: one value per cycle in while loading, one per cycle out while
// out_stall is low; a new set is not taken until the last one has unloaded.
// The work is done by a row of MAX_ITEMS cells kept in order: each new
// value is compared in every cell at once and the larger entries move one
// cell down. Unload shifts the row toward the head.
// in_stall is high while a set unloads. out_stall freezes the row, so the
// offered beat holds. Reset (synchronous, rst_n low) empties the row and
// clears the drop flag; no clearing pass is needed.
module ascending_sort_engine
  import ase_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [31:0]  in_value,
  input  logic         in_final_item,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [31:0]  out_sorted_value,
  output logic         out_end_of_run,
  output logic         out_dropped
);

  ase_state_t state_r, state_nxt;
  logic       overflow_r, overflow_nxt;

  cell_ctrl_t ctrl;
  cell_link_t link   [MAX_ITEMS];
  cell_link_t left_in  [MAX_ITEMS];
  cell_link_t right_in [MAX_ITEMS];

  logic in_beat, out_beat, full;

  assign full     = link[MAX_ITEMS-1].valid;
  assign in_stall = (state_r == ST_UNLOAD);
  assign in_beat  = in_valid && !in_stall;

  assign out_valid = (state_r == ST_UNLOAD) && link[0].valid;
  assign out_beat  = out_valid && !out_stall;

  assign ctrl.insert = in_beat && !full;
  assign ctrl.shift  = out_beat;
  assign ctrl.value  = value_t'(in_value);

  // neighbor wiring; head sees a non-larger left, tail sees an empty right
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_in[i] = '{value: '0, valid: 1'b1, gt: 1'b0};
    end else begin : g_mid_l
      assign left_in[i] = link[i-1];
    end
    if (i == MAX_ITEMS-1) begin : g_tail
      assign right_in[i] = '{value: '0, valid: 1'b0, gt: 1'b1};
    end else begin : g_mid_r
      assign right_in[i] = link[i+1];
    end

    ase_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .from_left  (left_in[i]),
      .from_right (right_in[i]),
      .to_nbr     (link[i])
    );
  end

  // last beat when the next cell is already empty
  assign out_sorted_value = 32'(link[0].value);
  assign out_end_of_run   = !link[1].valid;
  assign out_dropped      = overflow_r;

  always_comb begin
    state_nxt    = state_r;
    overflow_nxt = overflow_r;
    case (state_r)
      ST_LOAD: begin
        if (in_beat && full) begin
          overflow_nxt = 1'b1;
        end
        if (in_beat && in_final_item) begin
          state_nxt = ST_UNLOAD;
        end
      end
      ST_UNLOAD: begin
        if (out_beat && out_end_of_run) begin
          state_nxt    = ST_LOAD;
          overflow_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt    = ST_LOAD;
        overflow_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      overflow_r <= overflow_nxt;
    end
  end

endmodule

// ===== rtl/ase_checker.sv =====
module ase_checker
  import ase_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_final_item,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_sorted_value,
  input logic        out_end_of_run,
  input logic        out_dropped
);

  logic out_beat;
  assign out_beat = out_valid && !out_stall;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_value))
    else $error("stalled output beat changed");

  a_final_unloads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_final_item |=> out_valid && in_stall)
    else $error("final beat did not start unload");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && !out_end_of_run |=>
      out_valid && ($signed(out_sorted_value) >= $signed($past(out_sorted_value))))
    else $error("output not ascending");

  a_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && !out_end_of_run |=> out_dropped == $past(out_dropped))
    else $error("drop flag changed within a set");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_end_of_run |=> !out_valid && !in_stall)
    else $error("unload did not end after last beat");

endmodule

bind ascending_sort_engine ase_checker u_ase_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_final_item    (in_final_item),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sorted_value (out_sorted_value),
  .out_end_of_run   (out_end_of_run),
  .out_dropped      (out_dropped)
);

// ===== tb/ascending_sort_engine_test.sv =====
`timescale 1ns / 1ps

module ascending_sort_engine_test;
  import ase_pkg::*;

  // Run shape
  localparam int TARGET_ITEMS = 230;   // random part stops near this many values
  localparam int FULL_SET_AT  = 3;     // random set index that fills the store exactly
  localparam int OVER_SET_AT  = 8;     // random set index that runs past capacity
  localparam int OVER_EXTRA   = 4;     // values past capacity in that set
  localparam int HOLD_AT_BEAT = 6;     // sorted beat after which the receiver holds off
  localparam int HOLD_CYCLES  = 200;   // length of that hold-off
  localparam int DRAIN_CYCLES = 20;    // quiet time after the last expected beat
  localparam int CYCLE_LIMIT  = 50000; // watchdog

  // One pending input beat; gap is the idle time the driver leaves after it.
  typedef struct packed {
    value_t     value;
    logic       final_item;
    logic [1:0] gap;
  } in_beat_t;

  // One expected sorted beat.
  typedef struct packed {
    value_t sorted_value;
    logic   end_of_run;
    logic   dropped;
  } sorted_beat_t;

  // DUT ports; the inputs are known from time zero
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [31:0] in_value      = '0;
  logic        in_final_item = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [31:0] out_sorted_value;
  logic        out_end_of_run;
  logic        out_dropped;

  // Stimulus and scoreboard
  in_beat_t     pending_beats[$];
  sorted_beat_t sorted_due[$];
  int           beats_total   = 0;
  int           beats_taken   = 0;
  int           sets_sent     = 0;
  int           sets_dropped  = 0;
  int           sorted_seen   = 0;
  int           failures      = 0;
  int           cycle_cnt     = 0;

  // Shadow of the block: values collected for the open set
  value_t       set_store[MAX_ITEMS];
  int           set_count     = 0;
  logic         set_overflow  = 1'b0;

  // Driver / monitor private state
  int           idle_left     = 0;
  int           stall_left    = 0;
  in_beat_t     next_beat;
  sorted_beat_t want;

  ascending_sort_engine DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_final_item    (in_final_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_end_of_run   (out_end_of_run),
    .out_dropped      (out_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Sort predictor. Every accepted value goes into the shadow store unless
  // it is full, in which case the set is marked as having lost values. The
  // final beat closes the set even when its own value was dropped: the
  // stored values are exchange-sorted (signed) and queued as expected
  // beats, end_of_run on the last, dropped on all of them if any was lost.
  // ---------------------------------------------------------------------
  task automatic collect_value(input value_t v, input logic fin);
    value_t       row[MAX_ITEMS];
    value_t       t;
    sorted_beat_t b;
    if (set_count < MAX_ITEMS) begin
      set_store[set_count] = v;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (fin) begin
      for (int i = 0; i < set_count; i++) row[i] = set_store[i];
      for (int i = 0; i < set_count; i++) begin
        for (int j = i + 1; j < set_count; j++) begin
          if (row[i] > row[j]) begin
            t      = row[i];
            row[i] = row[j];
            row[j] = t;
          end
        end
      end
      for (int k = 0; k < set_count; k++) begin
        b.sorted_value = row[k];
        b.end_of_run   = (k == set_count - 1);
        b.dropped      = set_overflow;
        sorted_due.push_back(b);
      end
      sets_sent++;
      if (set_overflow) sets_dropped++;
      set_count    = 0;
      set_overflow = 1'b0;
    end
  endtask

  task automatic queue_beat(input value_t v, input logic fin, input logic [1:0] gap);
    in_beat_t b;
    b.value      = v;
    b.final_item = fin;
    b.gap        = gap;
    pending_beats.push_back(b);
  endtask

  // Value mix: clustered small numbers make duplicates likely, the
  // extremes hit the sign boundary, the rest is full 32-bit noise.
  function automatic value_t pick_value();
    int mode;
    mode = $urandom_range(0, 3);
    if (mode == 0) begin
      pick_value = value_t'($urandom_range(0, 8)) - 4;
    end else if (mode == 1) begin
      case ($urandom_range(0, 3))
        0:       pick_value = 32'h8000_0000;
        1:       pick_value = 32'h7fff_ffff;
        2:       pick_value = 32'h0000_0000;
        default: pick_value = 32'hffff_ffff;
      endcase
    end else begin
      pick_value = value_t'($urandom);
    end
  endfunction

  // A set of n random values; burst sets go in back to back.
  task automatic queue_set(input int n);
    logic burst;
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++)
      queue_beat(pick_value(), i == n - 1, burst ? 2'd0 : 2'($urandom_range(0, 3)));
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers pending beats, holds a stalled beat unchanged, and feeds
  // the predictor on every accepted beat.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        collect_value(value_t'(in_value), in_final_item);
        beats_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          next_beat     = pending_beats.pop_front();
          in_value      <= next_beat.value;
          in_final_item <= next_beat.final_item;
          in_valid      <= 1'b1;
          idle_left     = next_beat.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each accepted sorted beat against the oldest
  // expectation and draws the stall that follows it. Once, early on, it
  // holds off for a long stretch so the block backs up into in_stall while
  // the driver keeps offering the next set.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sorted_seen++;
        if (sorted_due.size() == 0) begin
          $error("sorted beat with nothing expected: sorted_value %0d",
                 $signed(out_sorted_value));
          failures++;
        end else begin
          want = sorted_due.pop_front();
          if (out_sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d",
                   want.sorted_value, $signed(out_sorted_value));
            failures++;
          end
          if (out_end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0b, actual %0b", want.end_of_run, out_end_of_run);
            failures++;
          end
          if (out_dropped !== want.dropped) begin
            $error("dropped: expected %0b, actual %0b", want.dropped, out_dropped);
            failures++;
          end
        end
        if (sorted_seen == HOLD_AT_BEAT)
          stall_left = HOLD_CYCLES;
        else if ((sorted_seen / 32) % 3 == 2)
          stall_left = 0;          // stretch with no receiver stalls
        else
          stall_left = $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sorted beats outstanding",
               cycle_cnt, sorted_due.size());
      $display("ascending_sort_engine regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int set_idx;

    // Directed: lone extremes, a mixed set across the sign boundary,
    // duplicates, descending and ascending order, a lone zero.
    queue_beat(32'h8000_0000, 1'b1, 2'($urandom_range(0, 3)));
    queue_beat(32'h7fff_ffff, 1'b1, 2'($urandom_range(0, 3)));
    queue_beat(32'h0000_0000, 1'b0, 2'd0);
    queue_beat(32'hffff_ffff, 1'b0, 2'd1);
    queue_beat(32'h7fff_ffff, 1'b0, 2'd0);
    queue_beat(32'h8000_0000, 1'b0, 2'd3);
    queue_beat(32'h0000_0001, 1'b1, 2'd0);
    queue_beat(5,  1'b0, 2'd0);
    queue_beat(5,  1'b0, 2'd2);
    queue_beat(-5, 1'b0, 2'd0);
    queue_beat(5,  1'b0, 2'd0);
    queue_beat(-5, 1'b1, 2'd1);
    for (int i = 3; i >= 0; i--)
      queue_beat(i, i == 0, 2'($urandom_range(0, 3)));
    queue_beat(10, 1'b0, 2'd0);
    queue_beat(20, 1'b0, 2'd0);
    queue_beat(30, 1'b1, 2'd0);
    queue_beat(32'h0000_0000, 1'b1, 2'd2);

    // Random sets, mostly short; one fills the store exactly, one runs
    // past it so that its final value is dropped too.
    set_idx = 0;
    while (pending_beats.size() < TARGET_ITEMS) begin
      if (set_idx == FULL_SET_AT)
        queue_set(MAX_ITEMS);
      else if (set_idx == OVER_SET_AT)
        queue_set(MAX_ITEMS + OVER_EXTRA);
      else
        queue_set($urandom_range(1, 10));
      set_idx++;
    end
    beats_total = pending_beats.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_taken < beats_total) @(posedge clk);
    while (sorted_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d values in %0d sets (%0d over capacity), %0d sorted beats checked",
             beats_total, sets_sent, sets_dropped, sorted_seen);
    $display("receiver hold-off of %0d cycles, %0d mismatches", HOLD_CYCLES, failures);
    if (failures == 0) begin
      $display("ascending_sort_engine regression: pass");
    end else begin
      $display("ascending_sort_engine regression: fail");
    end
    $finish;
  end

endmodule
